// File: src/isrs_pkg.sv
// Shared types and constants for the icon size record selector.
`default_nettype none

package isrs_pkg;

   localparam int INDEX_BITS = 24;
   localparam int START_BITS = 24;
   localparam int WORD_BITS  = 32;
   localparam int IDEAL_BITS = 16;
   localparam int COUNT_BITS = 2 * WORD_BITS;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX   = '1;
   localparam logic [IDEAL_BITS-1:0] IDEAL_RESET = IDEAL_BITS'(32);

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [WORD_BITS-1:0]  best_width;
      logic [WORD_BITS-1:0]  best_height;
      logic [START_BITS-1:0] first_pixel;
      logic                  overflow;
   } rsp_type;

   // parse position inside a record
   typedef enum logic [2:0] {
      ST_WIDTH  = 3'b001,
      ST_HEIGHT = 3'b010,
      ST_PIXELS = 3'b100
   } parse_state_type;

   // one word handed to the parser
   typedef struct packed {
      logic    valid;
      req_type data;
   } step_type;

   // result produced by the parser on a last word
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

`default_nettype wire

// File: src/isrs_judge.sv
// Replacement decision: compares a finished record's average edge against the best.
`default_nettype none

module isrs_judge (
   input  wire logic [isrs_pkg::WORD_BITS-1:0]  cur_width,
   input  wire logic [isrs_pkg::WORD_BITS-1:0]  cur_height,
   input  wire logic [isrs_pkg::WORD_BITS-1:0]  held_avg,
   input  wire logic                            have_best,
   input  wire logic [isrs_pkg::IDEAL_BITS-1:0] target_edge,
   output logic                                 take,
   output logic      [isrs_pkg::WORD_BITS-1:0]  cur_avg
);
   import isrs_pkg::*;

   logic [WORD_BITS:0]   cur_sum;
   logic [WORD_BITS-1:0] ideal;
   logic                 held_low;
   logic                 held_high;
   logic                 cur_reaches;

   always_comb begin
      cur_sum     = {1'b0, cur_width} + {1'b0, cur_height};
      cur_avg     = cur_sum[WORD_BITS:1];
      ideal       = WORD_BITS'(target_edge);
      held_low    = held_avg < ideal;
      held_high   = held_avg > ideal;
      cur_reaches = cur_avg >= ideal;
      take = !have_best ||
             (held_low && cur_reaches) ||
             (held_low && (cur_avg > held_avg)) ||
             (held_high && cur_reaches && (cur_avg < held_avg));
   end

endmodule

`default_nettype wire

// File: src/isrs_parser.sv
// Record parser: tracks position in the stream, counts pixels, keeps the best record.
`default_nettype none

module isrs_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [isrs_pkg::IDEAL_BITS-1:0] target_edge,
   input  wire isrs_pkg::step_type              step,
   output isrs_pkg::result_type                 result
);
   import isrs_pkg::*;

   parse_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0]   cur_width_ff, cur_width_in;
   logic [WORD_BITS-1:0]   cur_height_ff, cur_height_in;
   logic [COUNT_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic [INDEX_BITS-1:0]  word_index_ff, word_index_in;
   logic [INDEX_BITS-1:0]  pixel_start_ff, pixel_start_in;
   logic [WORD_BITS-1:0]   held_width_ff, held_width_in;
   logic [WORD_BITS-1:0]   held_height_ff, held_height_in;
   logic [WORD_BITS-1:0]   held_avg_ff, held_avg_in;
   logic [INDEX_BITS-1:0]  held_start_ff, held_start_in;
   logic                   have_best_ff, have_best_in;
   logic                   overflow_ff, overflow_in;

   logic [WORD_BITS-1:0]   judge_width;
   logic [WORD_BITS-1:0]   judge_height;
   logic [INDEX_BITS-1:0]  judge_start;
   logic                   take;
   logic [WORD_BITS-1:0]   cur_avg;
   logic                   do_judge;
   logic                   short_tail;
   logic                   idx_at_max;
   logic [INDEX_BITS-1:0]  index_next;
   logic [COUNT_BITS-1:0]  product;
   logic                   found;

   isrs_judge u_judge (
      .cur_width   (judge_width),
      .cur_height  (judge_height),
      .held_avg    (held_avg_ff),
      .have_best   (have_best_ff),
      .target_edge (target_edge),
      .take        (take),
      .cur_avg     (cur_avg)
   );

   assign product = COUNT_BITS'(cur_width_ff) * COUNT_BITS'(step.data.word);

   always_comb begin
      state_in       = state_ff;
      cur_width_in   = cur_width_ff;
      cur_height_in  = cur_height_ff;
      pixels_left_in = pixels_left_ff;
      word_index_in  = word_index_ff;
      pixel_start_in = pixel_start_ff;
      held_width_in  = held_width_ff;
      held_height_in = held_height_ff;
      held_avg_in    = held_avg_ff;
      held_start_in  = held_start_ff;
      have_best_in   = have_best_ff;
      overflow_in    = overflow_ff;
      do_judge       = 1'b0;
      short_tail     = 1'b0;

      // index saturates at its maximum; the next index is also the pixel start
      idx_at_max = word_index_ff == INDEX_MAX;
      index_next = idx_at_max ? word_index_ff : word_index_ff + 1'b1;

      judge_width  = cur_width_ff;
      judge_height = cur_height_ff;
      judge_start  = pixel_start_ff;

      unique case (state_ff)
         ST_HEIGHT: begin
            judge_height = step.data.word;
            judge_start  = index_next;
         end
         default: begin
         end
      endcase

      if (step.valid) begin
         word_index_in = index_next;
         overflow_in   = overflow_ff | idx_at_max;
         unique case (state_ff)
            ST_HEIGHT: begin
               cur_height_in  = step.data.word;
               pixels_left_in = product;
               pixel_start_in = index_next;
               if (step.data.last) begin
                  short_tail = 1'b1;
               end else if (cur_width_ff == '0 || step.data.word == '0) begin
                  // empty record finishes on its height word
                  do_judge = 1'b1;
                  state_in = ST_WIDTH;
               end else begin
                  state_in = ST_PIXELS;
               end
            end
            ST_PIXELS: begin
               if (pixels_left_ff != '0) begin
                  pixels_left_in = pixels_left_ff - 1'b1;
               end
               if (pixels_left_ff[COUNT_BITS-1:1] == '0) begin
                  do_judge = 1'b1;
                  state_in = ST_WIDTH;
               end
            end
            default: begin
               cur_width_in = step.data.word;
               state_in     = ST_HEIGHT;
               short_tail   = step.data.last;
            end
         endcase

         if (do_judge && take) begin
            have_best_in   = 1'b1;
            held_width_in  = judge_width;
            held_height_in = judge_height;
            held_avg_in    = cur_avg;
            held_start_in  = judge_start;
         end
      end

      found              = have_best_in && !short_tail;
      result.valid       = step.valid && step.data.last;
      result.data.found       = found;
      result.data.best_width  = found ? held_width_in : '0;
      result.data.best_height = found ? held_height_in : '0;
      result.data.first_pixel = found ? START_BITS'(held_start_in) : '0;
      result.data.overflow    = overflow_in;

      // end of list: start a fresh stream
      if (result.valid) begin
         state_in      = ST_WIDTH;
         word_index_in = '0;
         have_best_in  = 1'b0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIDTH;
         word_index_ff <= '0;
         have_best_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_index_ff <= word_index_in;
         have_best_ff  <= have_best_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_width_ff   <= cur_width_in;
      cur_height_ff  <= cur_height_in;
      pixels_left_ff <= pixels_left_in;
      pixel_start_ff <= pixel_start_in;
      held_width_ff  <= held_width_in;
      held_height_ff <= held_height_in;
      held_avg_ff    <= held_avg_in;
      held_start_ff  <= held_start_in;
   end

endmodule

`default_nettype wire

// File: src/icon_size_record_selector.sv
// Throughput: one word per cycle, but a last word waits while the result
// register still holds an unaccepted result. Each word passes the input
// register, then one pass of parser logic (a 32x32 multiply on the height
// word, a 64-bit countdown on pixel words, an average compare) into the result
// register. Reset is synchronous, active high: clears the stream state and both
// channel registers, and sets the target edge length to 32.
`default_nettype none

module icon_size_record_selector (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire isrs_pkg::req_type               req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output isrs_pkg::rsp_type                    rsp_payload,
   input  wire logic                            csr_we,
   input  wire logic [isrs_pkg::IDEAL_BITS-1:0] csr_wdata
);
   import isrs_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_ff, in_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [IDEAL_BITS-1:0] target_edge_ff, target_edge_in;
   logic                  in_fire;
   step_type              step;
   result_type            result;

   // a word that ends the list needs room in the result register
   assign in_fire   = in_valid_ff && (!in_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || in_fire;

   assign step.valid = in_fire;
   assign step.data  = in_ff;

   isrs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .target_edge (target_edge_ff),
      .step        (step),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_in       = req_payload;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      target_edge_in = csr_we ? csr_wdata : target_edge_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         target_edge_ff <= IDEAL_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         target_edge_ff <= target_edge_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the icon size record selector: directed streams, then random ones.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isrs_pkg::*;

   localparam int STALL_LIMIT = 5000;

   // how a generated record ends
   typedef enum int {
      REC_FULL,
      REC_END,
      REC_CUT,
      REC_ON_WIDTH,
      REC_ON_HEIGHT
   } rec_end_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [IDEAL_BITS-1:0] csr_wdata = '0;

   icon_size_record_selector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   req_type word_queue[$];
   rsp_type selection_queue[$];
   int words_made = 0;
   int mismatches = 0;
   int send_idle = 35;
   int recv_idle = 52;
   int stall_cycles = 0;

   // predictor state
   logic [IDEAL_BITS-1:0] ideal = IDEAL_RESET;
   parse_state_type seen = ST_WIDTH;
   logic [WORD_BITS-1:0] cur_w = '0;
   logic [WORD_BITS-1:0] cur_h = '0;
   logic [COUNT_BITS-1:0] left = '0;
   logic [INDEX_BITS-1:0] word_idx = '0;
   logic [INDEX_BITS-1:0] pix_start = '0;
   logic [WORD_BITS-1:0] held_w = '0;
   logic [WORD_BITS-1:0] held_h = '0;
   logic [INDEX_BITS-1:0] held_start = '0;
   logic have_best = 1'b0;
   logic ovf = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [WORD_BITS-1:0] edge_avg(logic [WORD_BITS-1:0] a,
                                                      logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WORD_BITS:1];
   endfunction

   task automatic weigh_record();
      logic [WORD_BITS-1:0] held_avg, this_avg, goal;
      logic take;
      goal = WORD_BITS'(ideal);
      held_avg = edge_avg(held_w, held_h);
      this_avg = edge_avg(cur_w, cur_h);
      take = !have_best
         || (held_avg < goal && this_avg >= goal)
         || (held_avg < goal && this_avg > held_avg)
         || (held_avg > goal && this_avg >= goal && this_avg < held_avg);
      if (take) begin
         have_best = 1'b1;
         held_w = cur_w;
         held_h = cur_h;
         held_start = pix_start;
      end
   endtask

   task automatic absorb_word(req_type r);
      logic [INDEX_BITS-1:0] at;
      logic tail_cut;
      rsp_type res;
      at = word_idx;
      tail_cut = 1'b0;
      if (word_idx == INDEX_MAX) begin
         ovf = 1'b1;
      end else begin
         word_idx = word_idx + 1'b1;
      end
      case (seen)
         ST_HEIGHT: begin
            cur_h = r.word;
            left = COUNT_BITS'(cur_w) * COUNT_BITS'(cur_h);
            pix_start = (at == INDEX_MAX) ? INDEX_MAX : at + 1'b1;
            if (r.last) begin
               tail_cut = 1'b1;
            end else if (left == 0) begin
               weigh_record();
               seen = ST_WIDTH;
            end else begin
               seen = ST_PIXELS;
            end
         end
         ST_PIXELS: begin
            if (left != 0) left = left - 1'b1;
            if (left == 0) begin
               weigh_record();
               seen = ST_WIDTH;
            end
         end
         default: begin
            cur_w = r.word;
            seen = ST_HEIGHT;
            if (r.last) tail_cut = 1'b1;
         end
      endcase
      if (r.last) begin
         res.found = have_best && !tail_cut;
         res.best_width = res.found ? held_w : '0;
         res.best_height = res.found ? held_h : '0;
         res.first_pixel = res.found ? START_BITS'(held_start) : '0;
         res.overflow = ovf;
         selection_queue.push_back(res);
         seen = ST_WIDTH;
         cur_w = '0;
         cur_h = '0;
         left = '0;
         word_idx = '0;
         pix_start = '0;
         held_w = '0;
         held_h = '0;
         held_start = '0;
         have_best = 1'b0;
         ovf = 1'b0;
      end
   endtask

   task automatic put(logic [WORD_BITS-1:0] w, logic l);
      word_queue.push_back(req_type'{word: w, last: l});
      words_made++;
   endtask

   task automatic emit_record(rec_end_type how);
      logic [WORD_BITS-1:0] w, h;
      logic [COUNT_BITS-1:0] npix;
      longint count;
      int pick;
      longint k;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         // zero pixel record, other edge anywhere in range
         w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 90);
         h = '0;
         if ($urandom_range(0, 1)) begin
            h = w;
            w = '0;
         end
      end else if (pick < 8) begin
         w = $urandom_range(1, 4);
         h = $urandom_range(1, 6);
      end else begin
         w = 1;
         h = $urandom_range(1, 80);
         if ($urandom_range(0, 1)) begin
            w = h;
            h = 1;
         end
      end
      if (how == REC_CUT && $urandom_range(0, 2) == 0) begin
         w = $urandom | 1;
         h = $urandom | 1;
      end
      npix = COUNT_BITS'(w) * COUNT_BITS'(h);
      if (how == REC_CUT && npix < 2) how = REC_END;
      put(w, how == REC_ON_WIDTH);
      if (how == REC_ON_WIDTH) return;
      put(h, how == REC_ON_HEIGHT || (how == REC_END && npix == 0));
      if (how == REC_ON_HEIGHT || npix == 0) return;
      if (how == REC_CUT) begin
         count = $urandom_range(1, (npix > 5) ? 4 : int'(npix) - 1);
      end else begin
         count = longint'(npix);
      end
      for (k = 1; k <= count; k++) begin
         put($urandom, how != REC_FULL && k == count);
      end
   endtask

   task automatic emit_stream();
      int n, r, i;
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) emit_record(REC_FULL);
      r = $urandom_range(0, 9);
      if (r < 6) emit_record(REC_END);
      else if (r < 8) emit_record(REC_CUT);
      else if (r == 8) emit_record(REC_ON_WIDTH);
      else emit_record(REC_ON_HEIGHT);
   endtask

   // wait until the block has nothing in flight
   task automatic settle();
      while (word_queue.size() != 0 || req_valid || selection_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_ideal(logic [IDEAL_BITS-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      ideal = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) absorb_word(req_payload);
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_valid <= 1'b1;
               req_payload <= word_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (selection_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: found=%0b w=%0h h=%0h start=%0h ovf=%0b",
                           rsp_payload.found, rsp_payload.best_width,
                           rsp_payload.best_height, rsp_payload.first_pixel,
                           rsp_payload.overflow);
            end else begin
               want = selection_queue.pop_front();
               if (rsp_payload.found !== want.found
                   || rsp_payload.best_width !== want.best_width
                   || rsp_payload.best_height !== want.best_height
                   || rsp_payload.first_pixel !== want.first_pixel
                   || rsp_payload.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected found=%0b w=%0h h=%0h start=%0h ovf=%0b, %s",
                              want.found, want.best_width, want.best_height,
                              want.first_pixel, want.overflow,
                              $sformatf("got found=%0b w=%0h h=%0h start=%0h ovf=%0b",
                                        rsp_payload.found, rsp_payload.best_width,
                                        rsp_payload.best_height, rsp_payload.first_pixel,
                                        rsp_payload.overflow));
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int target;
      logic [IDEAL_BITS-1:0] setting;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed streams at the reset ideal size
      put(32'h1, 1'b0); put(32'h1, 1'b0); put(32'hFFFF_FFFF, 1'b1);
      put(32'h0, 1'b1);                                   // ends on width word
      put(32'h2, 1'b0); put(32'h0, 1'b0); put(32'h0, 1'b1); // best held, short tail
      put(32'h0, 1'b0); put(32'hFFFF_FFFF, 1'b0);          // empty records, huge edges
      put(32'hFFFF_FFFF, 1'b0); put(32'h0, 1'b0);
      put(32'h1, 1'b0); put(32'h1, 1'b0); put(32'h0, 1'b1);
      put(32'h1, 1'b0); put(32'h2, 1'b0);                  // a full two-pixel record, then a truncated one
      put(32'hA5A5_A5A5, 1'b0); put(32'h5A5A_5A5A, 1'b0);
      put(32'h3, 1'b0); put(32'h3, 1'b0); put(32'h1, 1'b0); put(32'h2, 1'b1);
      put(32'h4, 1'b0); put(32'h7, 1'b1);                  // ends on height word
      settle();

      // the index limit lies far beyond any stream this run can send
      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin send_idle = 35; recv_idle = 52; end
            1: begin send_idle = 52; recv_idle = 35; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (phase)
            0: setting = '0;
            1: setting = '1;
            2: setting = $urandom_range(0, 40);
            3: setting = IDEAL_RESET;
            4: setting = $urandom_range(1, 20);
            default: setting = $urandom_range(0, 65535);
         endcase
         write_ideal(setting);
         @(negedge clock);
         target = words_made + 305;
         while (words_made < target) emit_stream();
         settle();
      end

      if (mismatches == 0 && selection_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
src/isrs_pkg.sv
src/isrs_judge.sv
src/isrs_parser.sv
src/icon_size_record_selector.sv
verif/testbench.sv
